/* rtl/pwss_pkg.sv */
// ----------------------------------------------------------------------------
// pwss_pkg
// Shared types, codes and defaults for the power window stall sequencer.
// ----------------------------------------------------------------------------
package pwss_pkg;

   localparam int CURRENT_BITS_DEF = 12;
   localparam int COUNT_BITS_DEF   = 16;

   localparam int THRESH_BITS = 12;
   localparam int LIMIT_BITS  = 16;
   localparam int DATA_BITS   = 32;
   localparam int ADDR_BITS   = 3;
   localparam int NUM_LANES   = 4;

   localparam logic [THRESH_BITS-1:0] THRESH_RESET = 12'd2048;
   localparam logic [LIMIT_BITS-1:0]  LIMIT_RESET  = 16'd10;

   // register index, taken from paddr[2]
   localparam logic CSR_IDX_THRESHOLD = 1'b0;
   localparam logic CSR_IDX_LIMIT     = 1'b1;

   // lane order
   localparam int W_LR = 0;
   localparam int W_RR = 1;
   localparam int W_LF = 2;
   localparam int W_RF = 3;

   typedef logic [1:0] motion_type;
   localparam motion_type MV_IDLE = 2'd0;
   localparam motion_type MV_UP   = 2'd1;
   localparam motion_type MV_DOWN = 2'd2;

   typedef logic [1:0] drive_type;
   localparam drive_type DRV_IDLE = 2'd0;
   localparam drive_type DRV_DOWN = 2'd1;
   localparam drive_type DRV_UP   = 2'd2;

   localparam logic [1:0] MODE_READY    = 2'd0;
   localparam logic [1:0] MODE_ALL_UP   = 2'd1;
   localparam logic [1:0] MODE_ALL_DOWN = 2'd2;

   localparam logic [2:0] STEP_READY      = 3'd0;
   localparam logic [2:0] STEP_REAR_RUN   = 3'd1;
   localparam logic [2:0] STEP_REAR_DONE  = 3'd2;
   localparam logic [2:0] STEP_FRONT_RUN  = 3'd3;
   localparam logic [2:0] STEP_FRONT_DONE = 3'd4;

   localparam logic [2:0] GRP_FRONT_PAIR  = 3'd0;
   localparam logic [2:0] GRP_ALL_STAGED  = 3'd1;
   localparam logic [2:0] GRP_LEFT_FRONT  = 3'd2;
   localparam logic [2:0] GRP_RIGHT_FRONT = 3'd3;

   localparam logic [1:0] DIR_UP   = 2'd1;
   localparam logic [1:0] DIR_DOWN = 2'd2;

   // per-lane control for one transaction
   typedef struct packed {
      logic       ev_hit;
      motion_type ev_motion;
      logic       tap;
      logic       stage_set;
      motion_type stage_motion;
   } lane_ctrl_type;

   // touch event as seen by the stager
   typedef struct packed {
      logic ev_all;
      logic ev_up;
      logic tap;
   } stage_event_type;

   // pair commands from the stager
   typedef struct packed {
      logic       rear_set;
      logic       front_set;
      motion_type motion;
   } stage_cmd_type;

   typedef struct packed {
      drive_type lf_drive;
      drive_type rf_drive;
      drive_type lr_drive;
      drive_type rr_drive;
      logic      staging_busy;
   } result_type;

   function automatic drive_type drive_code(input motion_type m);
      drive_type d;
      d = DRV_IDLE;
      if (m == MV_UP) begin
         d = DRV_UP;
      end else if (m == MV_DOWN) begin
         d = DRV_DOWN;
      end
      return d;
   endfunction

endpackage

/* rtl/power_window_stall_sequencer_core.sv */
// ----------------------------------------------------------------------------
// power_window_stall_sequencer_core
// Four-window motor controller with stall detection and staged all-up/down.
//
// Usage:
//   req_* carries one control tick: touch event, tap and eight current samples.
//   rsp_* returns one transaction per tick: four pin drives and staging_busy.
//   Both channels use valid/stall; a transaction moves when valid is high and
//   stall is low. psel/penable/pwrite/paddr/pwdata/prdata/pready form the
//   register port: threshold at 0x0, stall count limit at 0x4.
//   The response is registered in the output register, or in the skid stage
//   while the receiver stalls. Throughput: one tick per cycle while req_stall
//   is low; the lanes and the stager compute each response combinationally.
//   A two-entry output (register plus skid stage) lets one more request in
//   while the receiver stalls; req_stall rises only once both are full.
//   Reset (synchronous) idles all windows, clears counters and the stager
//   and restores the register defaults (2048 and 10).
// ----------------------------------------------------------------------------
module power_window_stall_sequencer_core #(
   parameter int CURRENT_BITS = pwss_pkg::CURRENT_BITS_DEF,
   parameter int COUNT_BITS   = pwss_pkg::COUNT_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_on_window_screen,
   input  logic [2:0]                     req_target_group,
   input  logic [1:0]                     req_swipe_dir,
   input  logic                           req_stop_tap,
   input  logic [CURRENT_BITS-1:0]        req_lr_up_current,
   input  logic [CURRENT_BITS-1:0]        req_lr_down_current,
   input  logic [CURRENT_BITS-1:0]        req_rr_up_current,
   input  logic [CURRENT_BITS-1:0]        req_rr_down_current,
   input  logic [CURRENT_BITS-1:0]        req_lf_up_current,
   input  logic [CURRENT_BITS-1:0]        req_lf_down_current,
   input  logic [CURRENT_BITS-1:0]        req_rf_up_current,
   input  logic [CURRENT_BITS-1:0]        req_rf_down_current,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_lf_drive,
   output logic [1:0]                     rsp_rf_drive,
   output logic [1:0]                     rsp_lr_drive,
   output logic [1:0]                     rsp_rr_drive,
   output logic                           rsp_staging_busy,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [pwss_pkg::ADDR_BITS-1:0] paddr,
   input  logic [pwss_pkg::DATA_BITS-1:0] pwdata,
   output logic [pwss_pkg::DATA_BITS-1:0] prdata,
   output logic                           pready
);
   import pwss_pkg::*;

   logic [THRESH_BITS-1:0] threshold_ff;
   logic [LIMIT_BITS-1:0]  limit_ff;
   logic                   csr_write;
   logic                   csr_idx;

   logic                   accept;
   logic                   ev_valid;
   motion_type             ev_motion;
   stage_event_type        stage_event;
   stage_cmd_type          stage_cmd;
   logic                   busy;

   lane_ctrl_type          lane_ctrl [NUM_LANES];
   motion_type             lane_motion [NUM_LANES];
   logic [CURRENT_BITS-1:0] up_cur [NUM_LANES];
   logic [CURRENT_BITS-1:0] dn_cur [NUM_LANES];
   logic                   lane_ev_hit [NUM_LANES];

   result_type             result;
   result_type             rsp_data_ff, rsp_data_in;
   result_type             skid_data_ff, skid_data_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   skid_valid_ff, skid_valid_in;

   // register port
   assign pready    = 1'b1;
   assign csr_idx   = paddr[2];
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      prdata = '0;
      unique case (csr_idx)
         CSR_IDX_THRESHOLD: prdata = DATA_BITS'(threshold_ff);
         CSR_IDX_LIMIT:     prdata = DATA_BITS'(limit_ff);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESH_RESET;
         limit_ff     <= LIMIT_RESET;
      end else if (csr_write) begin
         if (csr_idx == CSR_IDX_THRESHOLD) begin
            threshold_ff <= pwdata[THRESH_BITS-1:0];
         end else begin
            limit_ff <= pwdata[LIMIT_BITS-1:0];
         end
      end
   end

   // event decode
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign ev_valid  = req_on_window_screen &&
                      ((req_swipe_dir == DIR_UP) || (req_swipe_dir == DIR_DOWN));
   assign ev_motion = (req_swipe_dir == DIR_UP) ? MV_UP : MV_DOWN;

   assign stage_event.ev_all = ev_valid && (req_target_group == GRP_ALL_STAGED);
   assign stage_event.ev_up  = (req_swipe_dir == DIR_UP);
   assign stage_event.tap    = req_stop_tap;

   assign lane_ev_hit[W_LR] = 1'b0;
   assign lane_ev_hit[W_RR] = 1'b0;
   assign lane_ev_hit[W_LF] = ev_valid && ((req_target_group == GRP_FRONT_PAIR) ||
                                           (req_target_group == GRP_LEFT_FRONT));
   assign lane_ev_hit[W_RF] = ev_valid && ((req_target_group == GRP_FRONT_PAIR) ||
                                           (req_target_group == GRP_RIGHT_FRONT));

   assign up_cur[W_LR] = req_lr_up_current;
   assign dn_cur[W_LR] = req_lr_down_current;
   assign up_cur[W_RR] = req_rr_up_current;
   assign dn_cur[W_RR] = req_rr_down_current;
   assign up_cur[W_LF] = req_lf_up_current;
   assign dn_cur[W_LF] = req_lf_down_current;
   assign up_cur[W_RF] = req_rf_up_current;
   assign dn_cur[W_RF] = req_rf_down_current;

   // window lanes
   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      always_comb begin
         lane_ctrl[g].ev_hit       = lane_ev_hit[g];
         lane_ctrl[g].ev_motion    = ev_motion;
         lane_ctrl[g].tap          = req_stop_tap;
         lane_ctrl[g].stage_set    = (g == W_LR || g == W_RR) ? stage_cmd.rear_set
                                                              : stage_cmd.front_set;
         lane_ctrl[g].stage_motion = stage_cmd.motion;
      end

      pwss_lane #(
         .CURRENT_BITS (CURRENT_BITS),
         .COUNT_BITS   (COUNT_BITS)
      ) u_lane (
         .clock        (clock),
         .reset        (reset),
         .accept       (accept),
         .ctrl         (lane_ctrl[g]),
         .threshold    (threshold_ff),
         .limit        (limit_ff),
         .up_current   (up_cur[g]),
         .down_current (dn_cur[g]),
         .motion_mid   (lane_motion[g])
      );
   end

   // merge stage
   pwss_stager u_stager (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .event_in   (stage_event),
      .rear_idle  ((lane_motion[W_LR] == MV_IDLE) && (lane_motion[W_RR] == MV_IDLE)),
      .front_idle ((lane_motion[W_LF] == MV_IDLE) && (lane_motion[W_RF] == MV_IDLE)),
      .cmd        (stage_cmd),
      .busy       (busy)
   );

   assign result.lf_drive     = drive_code(lane_motion[W_LF]);
   assign result.rf_drive     = drive_code(lane_motion[W_RF]);
   assign result.lr_drive     = drive_code(lane_motion[W_LR]);
   assign result.rr_drive     = drive_code(lane_motion[W_RR]);
   assign result.staging_busy = busy;

   // output register with skid stage
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!rsp_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else if (accept) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = result;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_lf_drive     = rsp_data_ff.lf_drive;
   assign rsp_rf_drive     = rsp_data_ff.rf_drive;
   assign rsp_lr_drive     = rsp_data_ff.lr_drive;
   assign rsp_rr_drive     = rsp_data_ff.rr_drive;
   assign rsp_staging_busy = rsp_data_ff.staging_busy;

endmodule

/* rtl/pwss_lane.sv */
// ----------------------------------------------------------------------------
// pwss_lane
// One window: motion state plus saturating up and down stall counters.
// ----------------------------------------------------------------------------
module pwss_lane #(
   parameter int CURRENT_BITS = pwss_pkg::CURRENT_BITS_DEF,
   parameter int COUNT_BITS   = pwss_pkg::COUNT_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  pwss_pkg::lane_ctrl_type          ctrl,
   input  logic [pwss_pkg::THRESH_BITS-1:0] threshold,
   input  logic [pwss_pkg::LIMIT_BITS-1:0]  limit,
   input  logic [CURRENT_BITS-1:0]          up_current,
   input  logic [CURRENT_BITS-1:0]          down_current,
   output pwss_pkg::motion_type             motion_mid
);
   import pwss_pkg::*;

   localparam int CUR_W = (CURRENT_BITS > THRESH_BITS) ? CURRENT_BITS : THRESH_BITS;
   localparam int CNT_W = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;

   motion_type            motion_ff, motion_in;
   logic [COUNT_BITS-1:0] up_cnt_ff, up_cnt_in;
   logic [COUNT_BITS-1:0] dn_cnt_ff, dn_cnt_in;
   logic                  up_high, dn_high, stalled;

   assign up_high = CUR_W'(up_current) >= CUR_W'(threshold);
   assign dn_high = CUR_W'(down_current) >= CUR_W'(threshold);

   always_comb begin
      up_cnt_in = '0;
      dn_cnt_in = '0;
      if (up_high) begin
         up_cnt_in = (&up_cnt_ff) ? up_cnt_ff : up_cnt_ff + 1'b1;
      end
      if (dn_high) begin
         dn_cnt_in = (&dn_cnt_ff) ? dn_cnt_ff : dn_cnt_ff + 1'b1;
      end
   end

   assign stalled = (CNT_W'(up_cnt_in) >= CNT_W'(limit)) ||
                    (CNT_W'(dn_cnt_in) >= CNT_W'(limit));

   always_comb begin
      motion_mid = motion_ff;
      if (ctrl.ev_hit) begin
         motion_mid = ctrl.ev_motion;
      end
      if (ctrl.tap || stalled) begin
         motion_mid = MV_IDLE;
      end
      motion_in = ctrl.stage_set ? ctrl.stage_motion : motion_mid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         motion_ff <= MV_IDLE;
         up_cnt_ff <= '0;
         dn_cnt_ff <= '0;
      end else if (accept) begin
         motion_ff <= motion_in;
         up_cnt_ff <= up_cnt_in;
         dn_cnt_ff <= dn_cnt_in;
      end
   end

endmodule

/* rtl/pwss_stager.sv */
// ----------------------------------------------------------------------------
// pwss_stager
// Merges the lanes' idle status and runs the staged all-up / all-down sequence.
// ----------------------------------------------------------------------------
module pwss_stager (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  pwss_pkg::stage_event_type event_in,
   input  logic                      rear_idle,
   input  logic                      front_idle,
   output pwss_pkg::stage_cmd_type   cmd,
   output logic                      busy
);
   import pwss_pkg::*;

   logic [1:0] mode_ff, mode_in, mode_mid;
   logic [2:0] step_ff, step_in, step_mid;

   always_comb begin
      mode_mid = mode_ff;
      step_mid = step_ff;
      if (event_in.ev_all) begin
         mode_mid = event_in.ev_up ? MODE_ALL_UP : MODE_ALL_DOWN;
      end
      if (event_in.tap) begin
         mode_mid = MODE_READY;
         step_mid = STEP_READY;
      end
   end

   assign busy = (mode_mid != MODE_READY);

   always_comb begin
      mode_in       = mode_mid;
      step_in       = step_mid;
      cmd.rear_set  = 1'b0;
      cmd.front_set = 1'b0;
      cmd.motion    = (mode_mid == MODE_ALL_UP) ? MV_UP : MV_DOWN;
      if (mode_mid == MODE_ALL_UP) begin
         unique case (step_mid)
            STEP_READY: begin
               step_in = STEP_REAR_RUN;
            end
            STEP_REAR_RUN: begin
               cmd.rear_set = 1'b1;
               step_in      = STEP_REAR_DONE;
            end
            STEP_REAR_DONE: begin
               if (rear_idle) step_in = STEP_FRONT_RUN;
            end
            STEP_FRONT_RUN: begin
               cmd.front_set = 1'b1;
               step_in       = STEP_FRONT_DONE;
            end
            STEP_FRONT_DONE: begin
               if (front_idle) begin
                  mode_in = MODE_READY;
                  step_in = STEP_READY;
               end
            end
            default: begin
            end
         endcase
      end else if (mode_mid == MODE_ALL_DOWN) begin
         unique case (step_mid)
            STEP_READY: begin
               step_in = STEP_FRONT_RUN;
            end
            STEP_FRONT_RUN: begin
               cmd.front_set = 1'b1;
               step_in       = STEP_FRONT_DONE;
            end
            STEP_FRONT_DONE: begin
               if (front_idle) step_in = STEP_REAR_RUN;
            end
            STEP_REAR_RUN: begin
               cmd.rear_set = 1'b1;
               step_in      = STEP_REAR_DONE;
            end
            STEP_REAR_DONE: begin
               if (rear_idle) begin
                  mode_in = MODE_READY;
                  step_in = STEP_READY;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_READY;
         step_ff <= STEP_READY;
      end else if (accept) begin
         mode_ff <= mode_in;
         step_ff <= step_in;
      end
   end

endmodule

/* tb/tb_power_window_stall_sequencer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_power_window_stall_sequencer_core
// Self-checking bench for the four-window stall sequencer. Touch events, taps
// and current samples are sent as request transactions, and a behavioral model
// of the windows, stall counters and stager predicts every response
// transaction. Directed tests cover the event groups, the staged all-up and
// all-down runs, the register extremes and the largest stall limit. A
// constrained random part follows, with random gaps on both channels and one
// long receiver hold-off that backs the block up into its request channel.
// ----------------------------------------------------------------------------
module tb_power_window_stall_sequencer_core;
   import pwss_pkg::*;

   localparam int CURRENT_W      = CURRENT_BITS_DEF;
   localparam int COUNT_W        = COUNT_BITS_DEF;
   localparam int CUR_MAX        = (1 << CURRENT_W) - 1;
   localparam int CNT_MAX        = (1 << COUNT_W) - 1;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_OFF_LEN   = 300;
   localparam int RANDOM_PHASES  = 6;
   localparam int PHASE_ITEMS    = 265;
   localparam int MAX_LIMIT_RUN  = 40;

   localparam logic [2:0] GRP_NONE = 3'd4;
   localparam logic [2:0] GRP_MAX  = 3'd7;
   localparam logic [1:0] DIR_NONE = 2'd0;
   localparam logic [1:0] DIR_BAD  = 2'd3;

   localparam logic [ADDR_BITS-1:0] ADDR_THRESHOLD = {CSR_IDX_THRESHOLD, 2'b00};
   localparam logic [ADDR_BITS-1:0] ADDR_LIMIT     = {CSR_IDX_LIMIT, 2'b00};

   typedef struct packed {
      logic                       on_screen;
      logic [2:0]                 group;
      logic [1:0]                 swipe;
      logic                       tap;
      logic [7:0][CURRENT_W-1:0]  cur;
   } touch_tick_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_on_window_screen;
   logic [2:0]            req_target_group;
   logic [1:0]            req_swipe_dir;
   logic                  req_stop_tap;
   logic [CURRENT_W-1:0]  req_lr_up_current;
   logic [CURRENT_W-1:0]  req_lr_down_current;
   logic [CURRENT_W-1:0]  req_rr_up_current;
   logic [CURRENT_W-1:0]  req_rr_down_current;
   logic [CURRENT_W-1:0]  req_lf_up_current;
   logic [CURRENT_W-1:0]  req_lf_down_current;
   logic [CURRENT_W-1:0]  req_rf_up_current;
   logic [CURRENT_W-1:0]  req_rf_down_current;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [1:0]            rsp_lf_drive;
   logic [1:0]            rsp_rf_drive;
   logic [1:0]            rsp_lr_drive;
   logic [1:0]            rsp_rr_drive;
   logic                  rsp_staging_busy;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [ADDR_BITS-1:0]  paddr;
   logic [DATA_BITS-1:0]  pwdata;
   logic [DATA_BITS-1:0]  prdata;
   logic                  pready;

   // model state
   motion_type            win_motion [4];
   logic [COUNT_W-1:0]    up_stall [4];
   logic [COUNT_W-1:0]    down_stall [4];
   logic [1:0]            seq_mode;
   logic [2:0]            seq_step;
   logic [THRESH_BITS-1:0] cfg_threshold;
   logic [LIMIT_BITS-1:0]  cfg_limit;

   result_type            expected_drives [$];
   result_type            drive_want;
   int                    mismatch_count = 0;
   int                    idle_cycles = 0;
   int                    hold_off = 0;
   int                    run_left [8];
   bit                    tx_idle_en = 1'b0;
   bit                    rx_idle_en = 1'b0;

   power_window_stall_sequencer_core u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_on_window_screen (req_on_window_screen),
      .req_target_group     (req_target_group),
      .req_swipe_dir        (req_swipe_dir),
      .req_stop_tap         (req_stop_tap),
      .req_lr_up_current    (req_lr_up_current),
      .req_lr_down_current  (req_lr_down_current),
      .req_rr_up_current    (req_rr_up_current),
      .req_rr_down_current  (req_rr_down_current),
      .req_lf_up_current    (req_lf_up_current),
      .req_lf_down_current  (req_lf_down_current),
      .req_rf_up_current    (req_rf_up_current),
      .req_rf_down_current  (req_rf_down_current),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_lf_drive         (rsp_lf_drive),
      .rsp_rf_drive         (rsp_rf_drive),
      .rsp_lr_drive         (rsp_lr_drive),
      .rsp_rr_drive         (rsp_rr_drive),
      .rsp_staging_busy     (rsp_staging_busy),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .prdata               (prdata),
      .pready               (pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // window and stager model
   // ------------------------------------------------------------------------
   function automatic void reset_window_model();
      int w;
      for (w = 0; w < NUM_LANES; w++) begin
         win_motion[w] = MV_IDLE;
         up_stall[w]   = '0;
         down_stall[w] = '0;
      end
      seq_mode      = MODE_READY;
      seq_step      = STEP_READY;
      cfg_threshold = THRESH_RESET;
      cfg_limit     = LIMIT_RESET;
   endfunction

   function automatic drive_type pins_for(input motion_type m);
      case (m)
         MV_UP:   return DRV_UP;
         MV_DOWN: return DRV_DOWN;
         default: return DRV_IDLE;
      endcase
   endfunction

   function automatic void set_pair(input int a, input int b, input motion_type m);
      win_motion[a] = m;
      win_motion[b] = m;
   endfunction

   function automatic logic pair_idle(input int a, input int b);
      return (win_motion[a] == MV_IDLE) && (win_motion[b] == MV_IDLE);
   endfunction

   function automatic logic [COUNT_W-1:0] next_stall_count(input logic [COUNT_W-1:0] c,
                                                           input logic [CURRENT_W-1:0] s);
      if (s >= cfg_threshold) begin
         return (c == CNT_MAX) ? c : c + 1'b1;
      end
      return '0;
   endfunction

   function automatic void step_sequencer();
      if (seq_mode == MODE_ALL_UP) begin
         case (seq_step)
            STEP_READY: seq_step = STEP_REAR_RUN;
            STEP_REAR_RUN: begin
               set_pair(W_LR, W_RR, MV_UP);
               seq_step = STEP_REAR_DONE;
            end
            STEP_REAR_DONE: if (pair_idle(W_LR, W_RR)) seq_step = STEP_FRONT_RUN;
            STEP_FRONT_RUN: begin
               set_pair(W_LF, W_RF, MV_UP);
               seq_step = STEP_FRONT_DONE;
            end
            STEP_FRONT_DONE: if (pair_idle(W_LF, W_RF)) begin
               seq_mode = MODE_READY;
               seq_step = STEP_READY;
            end
            default: ;
         endcase
      end else if (seq_mode == MODE_ALL_DOWN) begin
         case (seq_step)
            STEP_READY: seq_step = STEP_FRONT_RUN;
            STEP_FRONT_RUN: begin
               set_pair(W_LF, W_RF, MV_DOWN);
               seq_step = STEP_FRONT_DONE;
            end
            STEP_FRONT_DONE: if (pair_idle(W_LF, W_RF)) seq_step = STEP_REAR_RUN;
            STEP_REAR_RUN: begin
               set_pair(W_LR, W_RR, MV_DOWN);
               seq_step = STEP_REAR_DONE;
            end
            STEP_REAR_DONE: if (pair_idle(W_LR, W_RR)) begin
               seq_mode = MODE_READY;
               seq_step = STEP_READY;
            end
            default: ;
         endcase
      end
   endfunction

   function automatic result_type predict_drives(input touch_tick_type t);
      result_type r;
      motion_type m;
      int         w;
      m = (t.swipe == DIR_UP) ? MV_UP : MV_DOWN;
      if (t.on_screen && (t.swipe == DIR_UP || t.swipe == DIR_DOWN)) begin
         case (t.group)
            GRP_FRONT_PAIR:  set_pair(W_LF, W_RF, m);
            GRP_ALL_STAGED:  seq_mode = (t.swipe == DIR_UP) ? MODE_ALL_UP : MODE_ALL_DOWN;
            GRP_LEFT_FRONT:  win_motion[W_LF] = m;
            GRP_RIGHT_FRONT: win_motion[W_RF] = m;
            default: ;
         endcase
      end
      if (t.tap) begin
         seq_mode = MODE_READY;
         seq_step = STEP_READY;
         for (w = 0; w < NUM_LANES; w++) win_motion[w] = MV_IDLE;
      end
      for (w = 0; w < NUM_LANES; w++) begin
         up_stall[w]   = next_stall_count(up_stall[w], t.cur[2*w]);
         down_stall[w] = next_stall_count(down_stall[w], t.cur[2*w+1]);
      end
      for (w = 0; w < NUM_LANES; w++) begin
         if (up_stall[w] >= cfg_limit || down_stall[w] >= cfg_limit) win_motion[w] = MV_IDLE;
      end
      r.lf_drive     = pins_for(win_motion[W_LF]);
      r.rf_drive     = pins_for(win_motion[W_RF]);
      r.lr_drive     = pins_for(win_motion[W_LR]);
      r.rr_drive     = pins_for(win_motion[W_RR]);
      r.staging_busy = (seq_mode != MODE_READY);
      step_sequencer();
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // tick builders
   // ------------------------------------------------------------------------
   function automatic touch_tick_type make_tick(input logic on, input logic [2:0] grp,
                                                input logic [1:0] sw, input logic tap,
                                                input logic [7:0] hi);
      touch_tick_type t;
      int             c;
      t.on_screen = on;
      t.group     = grp;
      t.swipe     = sw;
      t.tap       = tap;
      for (c = 0; c < 8; c++) t.cur[c] = hi[c] ? CURRENT_W'(CUR_MAX) : '0;
      return t;
   endfunction

   // samples come in runs above threshold so that stalls actually trip
   function automatic touch_tick_type random_tick();
      touch_tick_type t;
      int             roll;
      int             run_cap;
      int             c;
      roll        = $urandom_range(0, 99);
      t.on_screen = 1'b1;
      t.tap       = 1'b0;
      t.group     = GRP_NONE;
      t.swipe     = DIR_NONE;
      if (roll < 55) begin
         if ($urandom_range(0, 1)) t.group = 3'($urandom_range(GRP_MAX, GRP_FRONT_PAIR));
      end else if (roll < 90) begin
         t.group = 3'($urandom_range(GRP_RIGHT_FRONT, GRP_FRONT_PAIR));
         t.swipe = 2'($urandom_range(DIR_DOWN, DIR_UP));
         t.tap   = (roll >= 85);
      end else begin
         t.on_screen = 1'($urandom_range(0, 1));
         t.group     = 3'($urandom_range(GRP_MAX, GRP_FRONT_PAIR));
         t.swipe     = 2'($urandom_range(DIR_BAD, DIR_NONE));
         t.tap       = ($urandom_range(0, 3) == 0);
      end
      run_cap = (cfg_limit > 40) ? 40 : int'(cfg_limit) + 3;
      for (c = 0; c < 8; c++) begin
         if (run_left[c] == 0 && $urandom_range(0, 11) == 0) begin
            run_left[c] = $urandom_range(1, run_cap);
         end
         if (run_left[c] > 0) begin
            t.cur[c] = CURRENT_W'($urandom_range(CUR_MAX, cfg_threshold));
            run_left[c]--;
         end else if (cfg_threshold == 0) begin
            t.cur[c] = CURRENT_W'($urandom);
         end else begin
            t.cur[c] = CURRENT_W'($urandom_range(cfg_threshold - 1, 0));
         end
      end
      return t;
   endfunction

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------
   task automatic send_tick(input touch_tick_type t);
      int gap;
      gap = tx_idle_en ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_on_window_screen <= t.on_screen;
      req_target_group     <= t.group;
      req_swipe_dir        <= t.swipe;
      req_stop_tap         <= t.tap;
      req_lr_up_current    <= t.cur[2*W_LR];
      req_lr_down_current  <= t.cur[2*W_LR+1];
      req_rr_up_current    <= t.cur[2*W_RR];
      req_rr_down_current  <= t.cur[2*W_RR+1];
      req_lf_up_current    <= t.cur[2*W_LF];
      req_lf_down_current  <= t.cur[2*W_LF+1];
      req_rf_up_current    <= t.cur[2*W_RF];
      req_rf_down_current  <= t.cur[2*W_RF+1];
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      expected_drives.push_back(predict_drives(t));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_drives.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [ADDR_BITS-1:0] addr, input logic [DATA_BITS-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (pready !== 1'b1) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input int thr, input int lim);
      drain_results();
      write_csr(ADDR_THRESHOLD, DATA_BITS'(thr));
      write_csr(ADDR_LIMIT, DATA_BITS'(lim));
      cfg_threshold = THRESH_BITS'(thr);
      cfg_limit     = LIMIT_BITS'(lim);
   endtask

   // ------------------------------------------------------------------------
   // response side
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
      mismatch_count++;
   endtask

   initial begin : receiver
      int n;
      forever begin
         if (hold_off > 0) begin
            n        = hold_off;
            hold_off = 0;
         end else begin
            n = rx_idle_en ? $urandom_range(0, 11) : 0;
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!(reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_drives.size() == 0) begin
            report_mismatch("unexpected transaction", 0, 0);
         end else begin
            drive_want = expected_drives.pop_front();
            if (rsp_lf_drive !== drive_want.lf_drive)
               report_mismatch("lf_drive", rsp_lf_drive, drive_want.lf_drive);
            if (rsp_rf_drive !== drive_want.rf_drive)
               report_mismatch("rf_drive", rsp_rf_drive, drive_want.rf_drive);
            if (rsp_lr_drive !== drive_want.lr_drive)
               report_mismatch("lr_drive", rsp_lr_drive, drive_want.lr_drive);
            if (rsp_rr_drive !== drive_want.rr_drive)
               report_mismatch("rr_drive", rsp_rr_drive, drive_want.rr_drive);
            if (rsp_staging_busy !== drive_want.staging_busy)
               report_mismatch("staging_busy", rsp_staging_busy, drive_want.staging_busy);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0) || (psel && penable)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_front_events();
      logic [2:0] g;
      tx_idle_en = 1'b1;
      rx_idle_en = 1'b1;
      send_tick(make_tick(1'b1, GRP_FRONT_PAIR, DIR_UP, 1'b0, 8'h00));
      send_tick(make_tick(1'b1, GRP_LEFT_FRONT, DIR_DOWN, 1'b0, 8'h00));
      send_tick(make_tick(1'b1, GRP_RIGHT_FRONT, DIR_DOWN, 1'b0, 8'h00));
      // off-screen event is ignored
      send_tick(make_tick(1'b0, GRP_FRONT_PAIR, DIR_UP, 1'b0, 8'h00));
      // unknown groups and swipes
      for (g = GRP_NONE; g != GRP_FRONT_PAIR; g++) begin
         send_tick(make_tick(1'b1, g, DIR_UP, 1'b0, 8'h00));
      end
      send_tick(make_tick(1'b1, GRP_FRONT_PAIR, DIR_BAD, 1'b0, 8'h00));
      send_tick(make_tick(1'b1, GRP_FRONT_PAIR, DIR_NONE, 1'b0, 8'h00));
      // tap wins over the event, and works off-screen
      send_tick(make_tick(1'b1, GRP_FRONT_PAIR, DIR_UP, 1'b1, 8'h00));
      send_tick(make_tick(1'b1, GRP_LEFT_FRONT, DIR_UP, 1'b0, 8'h00));
      send_tick(make_tick(1'b0, GRP_NONE, DIR_NONE, 1'b1, 8'h00));
   endtask

   task automatic test_staged_sequences();
      set_config(THRESH_RESET, 2);
      // all-up: rear pair, then front pair
      send_tick(make_tick(1'b1, GRP_ALL_STAGED, DIR_UP, 1'b0, 8'h00));
      send_tick(make_tick(1'b1, GRP_NONE, DIR_NONE, 1'b0, 8'h00));
      send_tick(make_tick(1'b1, GRP_NONE, DIR_NONE, 1'b0, 8'h00));
      repeat (3) send_tick(make_tick(1'b1, GRP_NONE, DIR_NONE, 1'b0, 8'h05));
      send_tick(make_tick(1'b1, GRP_NONE, DIR_NONE, 1'b0, 8'h00));
      send_tick(make_tick(1'b1, GRP_NONE, DIR_NONE, 1'b0, 8'h00));
      repeat (3) send_tick(make_tick(1'b1, GRP_NONE, DIR_NONE, 1'b0, 8'h50));
      send_tick(make_tick(1'b1, GRP_NONE, DIR_NONE, 1'b0, 8'h00));
      // all-down, switched to all-up mid-run, then stopped
      send_tick(make_tick(1'b1, GRP_ALL_STAGED, DIR_DOWN, 1'b0, 8'h00));
      send_tick(make_tick(1'b1, GRP_NONE, DIR_NONE, 1'b0, 8'h00));
      send_tick(make_tick(1'b1, GRP_ALL_STAGED, DIR_UP, 1'b0, 8'h00));
      send_tick(make_tick(1'b1, GRP_NONE, DIR_NONE, 1'b0, 8'hA0));
      send_tick(make_tick(1'b0, GRP_NONE, DIR_NONE, 1'b1, 8'h00));
   endtask

   task automatic test_register_extremes();
      set_config(CUR_MAX, 2);
      send_tick(make_tick(1'b1, GRP_FRONT_PAIR, DIR_UP, 1'b0, 8'hFF));
      send_tick(make_tick(1'b1, GRP_NONE, DIR_NONE, 1'b0, 8'hFF));
      set_config(0, 3);
      send_tick(make_tick(1'b1, GRP_FRONT_PAIR, DIR_DOWN, 1'b0, 8'h00));
      repeat (3) send_tick(make_tick(1'b1, GRP_NONE, DIR_NONE, 1'b0, 8'h00));
      // zero limit idles every window on every tick
      set_config(THRESH_RESET, 0);
      send_tick(make_tick(1'b1, GRP_FRONT_PAIR, DIR_UP, 1'b0, 8'h00));
      send_tick(make_tick(1'b1, GRP_ALL_STAGED, DIR_UP, 1'b0, 8'h00));
      repeat (3) send_tick(make_tick(1'b1, GRP_NONE, DIR_NONE, 1'b0, 8'h00));
   endtask

   task automatic test_backpressure();
      set_config(THRESH_RESET, LIMIT_RESET);
      tx_idle_en = 1'b0;
      rx_idle_en = 1'b0;
      hold_off   = HOLD_OFF_LEN;
      repeat (24) send_tick(random_tick());
   endtask

   task automatic test_random_traffic();
      int phase;
      int i;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0:       set_config(THRESH_RESET, LIMIT_RESET);
            1:       set_config(CUR_MAX, 1);
            2:       set_config(0, CNT_MAX);
            default: set_config($urandom_range(CUR_MAX - 1, 1), $urandom_range(30, 2));
         endcase
         for (i = 0; i < PHASE_ITEMS; i++) begin
            if (i % 64 == 0) begin
               tx_idle_en = ($urandom_range(0, 3) != 0);
               rx_idle_en = ($urandom_range(0, 3) != 0);
            end
            send_tick(random_tick());
         end
      end
   endtask

   task automatic test_max_limit_run();
      set_config(0, CNT_MAX);
      tx_idle_en = 1'b0;
      rx_idle_en = 1'b0;
      send_tick(make_tick(1'b1, GRP_FRONT_PAIR, DIR_UP, 1'b0, 8'h00));
      repeat (MAX_LIMIT_RUN) begin
         send_tick(make_tick(1'b1, GRP_NONE, DIR_NONE, 1'b0, 8'($urandom)));
      end
   endtask

   initial begin
      reset                <= 1'b1;
      req_valid            <= 1'b0;
      req_on_window_screen <= 1'b0;
      req_target_group     <= GRP_NONE;
      req_swipe_dir        <= DIR_NONE;
      req_stop_tap         <= 1'b0;
      req_lr_up_current    <= '0;
      req_lr_down_current  <= '0;
      req_rr_up_current    <= '0;
      req_rr_down_current  <= '0;
      req_lf_up_current    <= '0;
      req_lf_down_current  <= '0;
      req_rf_up_current    <= '0;
      req_rf_down_current  <= '0;
      psel                 <= 1'b0;
      penable              <= 1'b0;
      pwrite               <= 1'b0;
      paddr                <= '0;
      pwdata               <= '0;
      foreach (run_left[c]) run_left[c] = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      reset_window_model();

      test_front_events();
      test_staged_sequences();
      test_register_extremes();
      test_backpressure();
      test_random_traffic();
      test_max_limit_run();

      drain_results();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
